// ===== hw/rtl/msgid_pkg.sv =====
// ----------------------------------------------------------------------------
// msgid_pkg
// Shared types and constants for the MessagePack integer decoder.
// ----------------------------------------------------------------------------
package msgid_pkg;

  // Target width codes
  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2,
    WIDTH_64 = 2'd3
  } width_code_t;

  // Configuration register indexes
  localparam logic CFG_WIDTH_CODE = 1'b0;
  localparam logic CFG_IS_SIGNED  = 1'b1;

  localparam logic RESET_IS_SIGNED = 1'b1;

  // Header bytes
  localparam logic [7:0] HDR_UINT8  = 8'hCC;
  localparam logic [7:0] HDR_UINT16 = 8'hCD;
  localparam logic [7:0] HDR_UINT32 = 8'hCE;
  localparam logic [7:0] HDR_UINT64 = 8'hCF;
  localparam logic [7:0] HDR_INT8   = 8'hD0;
  localparam logic [7:0] HDR_INT16  = 8'hD1;
  localparam logic [7:0] HDR_INT32  = 8'hD2;
  localparam logic [7:0] HDR_INT64  = 8'hD3;
  localparam logic [7:0] NEG_FIXINT_MIN = 8'hE0;

  // Total item lengths of the multi-byte forms
  localparam logic [3:0] LEN_8BIT  = 4'd2;
  localparam logic [3:0] LEN_16BIT = 4'd3;
  localparam logic [3:0] LEN_32BIT = 4'd5;
  localparam logic [3:0] LEN_64BIT = 4'd9;

  typedef struct packed {
    logic [3:0]  remaining;
    logic [63:0] acc;
    logic        src_signed;
    logic [3:0]  total_len;
  } msgid_state_t;

  typedef struct packed {
    logic [63:0] value;
    logic        ok;
    logic [3:0]  length;
  } msgid_result_t;

endpackage

// ===== hw/rtl/msgid_step.sv =====
// ----------------------------------------------------------------------------
// msgid_step
// Combinational decode of one byte against the current item state: header
// classification, payload shift and final extension/wrap.
// ----------------------------------------------------------------------------
module msgid_step
  import msgid_pkg::*;
(
  input  logic [7:0]    data_byte,
  input  msgid_state_t  state,
  input  width_code_t   width_code,
  input  logic          is_signed,
  output msgid_state_t  state_next,
  output logic          emit,
  output msgid_result_t result
);

  logic [63:0] acc_shift;
  logic [3:0]  payload_len;
  logic        hdr_signed;

  // wrap to target width, extend by target signedness
  function automatic logic [63:0] fit_target(input logic [63:0] v, input width_code_t wc,
                                             input logic sgn);
    logic [63:0] r;
    r = v;
    unique case (wc)
      WIDTH_8:  r = {{56{sgn & v[7]}},  v[7:0]};
      WIDTH_16: r = {{48{sgn & v[15]}}, v[15:0]};
      WIDTH_32: r = {{32{sgn & v[31]}}, v[31:0]};
      WIDTH_64: r = v;
      default:  r = v;
    endcase
    return r;
  endfunction

  // sign-extend a signed source form from its payload width
  function automatic logic [63:0] src_extend(input logic [63:0] v, input logic [3:0] tlen,
                                             input logic s);
    logic [63:0] r;
    r = v;
    if (s) begin
      priority case (tlen)
        LEN_8BIT:  r = {{56{v[7]}},  v[7:0]};
        LEN_16BIT: r = {{48{v[15]}}, v[15:0]};
        LEN_32BIT: r = {{32{v[31]}}, v[31:0]};
        default:   r = v;
      endcase
    end
    return r;
  endfunction

  assign acc_shift = {state.acc[55:0], data_byte};

  // payload length of a header byte, 0 when not accepted
  always_comb begin
    payload_len = 4'd0;
    hdr_signed  = 1'b0;
    unique case (data_byte)
      HDR_UINT8:  payload_len = 4'd1;
      HDR_UINT16: if (width_code != WIDTH_8) payload_len = 4'd2;
      HDR_UINT32: if (width_code == WIDTH_32 || width_code == WIDTH_64) payload_len = 4'd4;
      HDR_UINT64: if (width_code == WIDTH_64) payload_len = 4'd8;
      HDR_INT8: begin
        hdr_signed = 1'b1;
        if (is_signed) payload_len = 4'd1;
      end
      HDR_INT16: begin
        hdr_signed = 1'b1;
        if (is_signed && width_code != WIDTH_8) payload_len = 4'd2;
      end
      HDR_INT32: begin
        hdr_signed = 1'b1;
        if (is_signed && (width_code == WIDTH_32 || width_code == WIDTH_64))
          payload_len = 4'd4;
      end
      HDR_INT64: begin
        hdr_signed = 1'b1;
        if (is_signed && width_code == WIDTH_64) payload_len = 4'd8;
      end
      default: payload_len = 4'd0;
    endcase
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    result     = '{value: 64'd0, ok: 1'b0, length: 4'd0};
    if (state.remaining != 4'd0) begin
      state_next.acc       = acc_shift;
      state_next.remaining = state.remaining - 4'd1;
      if (state.remaining == 4'd1) begin
        emit   = 1'b1;
        result = '{value:  fit_target(src_extend(acc_shift, state.total_len, state.src_signed),
                                      width_code, is_signed),
                   ok:     1'b1,
                   length: state.total_len};
      end
    end else if (!data_byte[7]) begin
      emit   = 1'b1;
      result = '{value: fit_target({56'd0, data_byte}, width_code, is_signed),
                 ok: 1'b1, length: 4'd1};
    end else if (data_byte >= NEG_FIXINT_MIN && is_signed) begin
      emit   = 1'b1;
      result = '{value: fit_target({{56{1'b1}}, data_byte}, width_code, is_signed),
                 ok: 1'b1, length: 4'd1};
    end else if (payload_len == 4'd0) begin
      // rejected header: failure beat, stay awaiting a header
      emit = 1'b1;
    end else begin
      state_next.remaining  = payload_len;
      state_next.total_len  = payload_len + 4'd1;
      state_next.src_signed = hdr_signed;
      state_next.acc        = 64'd0;
    end
  end

endmodule

// ===== hw/rtl/msgpack_integer_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// msgpack_integer_decoder_unit
// Path from byte accept to the result beat: the input reg, then the result reg.
// Throughput: one byte per cycle; a stalled result holds only bytes that emit.
// Reset (rst, synchronous): awaiting header, pipeline empty, width 64, signed.
// Configuration writes take effect on the next cycle; write only when idle.
// ----------------------------------------------------------------------------
module msgpack_integer_decoder_unit
  import msgid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  // byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  // result
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic        ok,
  output logic [3:0]  length
);

  width_code_t   width_code;
  logic          is_signed;

  logic          byte_valid;
  logic [7:0]    byte_reg;

  msgid_state_t  state;
  msgid_state_t  state_next;
  logic          emit;
  msgid_result_t result;

  logic          out_free;
  logic          advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_code <= WIDTH_64;
      is_signed  <= RESET_IS_SIGNED;
    end else if (cfg_write_en) begin
      if (cfg_index == CFG_WIDTH_CODE) width_code <= width_code_t'(cfg_data);
      else                             is_signed  <= cfg_data[0];
    end
  end

  msgid_step u_step (
    .data_byte  (byte_reg),
    .state      (state),
    .width_code (width_code),
    .is_signed  (is_signed),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  assign out_free = !out_valid || out_ready;
  assign advance  = byte_valid && (!emit || out_free);
  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_reg <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{remaining: 4'd0, acc: 64'd0, src_signed: 1'b0, total_len: 4'd0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      value  <= result.value;
      ok     <= result.ok;
      length <= result.length;
    end
  end

  // failure beats carry nothing
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> length == 4'd0 && value == 64'd0)
    else $error("failure beat with nonzero payload");

  // good beats only carry lengths of real forms
  assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> length == 4'd1 || length == LEN_8BIT || length == LEN_16BIT ||
                        length == LEN_32BIT || length == LEN_64BIT)
    else $error("bad item length");

  // payload count never exceeds the longest form
  assert property (@(posedge clk) disable iff (rst) state.remaining <= 4'd8)
    else $error("payload count out of range");

  // an accepted byte is held in the input register next cycle
  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> byte_valid)
    else $error("accepted byte lost");

endmodule

// ===== tb/msgid_result_checker.sv =====
// ----------------------------------------------------------------------------
// msgid_result_checker
// Watches the byte stream, the register port and the result channel of the
// MessagePack integer decoder. Each accepted byte runs through a cycle-free
// model of the decoder; any result it yields is queued and compared field by
// field with the next result beat. Mismatch and pending counts go to the top.
// ----------------------------------------------------------------------------
module msgid_result_checker
  import msgid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] value,
  input  logic        ok,
  input  logic [3:0]  length,
  output int          mismatches,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  width_code_t cfg_width;
  logic        cfg_signed;

  // Item in progress
  logic [3:0]  payload_left;
  logic [63:0] shift_reg;
  logic        signed_form;
  logic [3:0]  item_len;

  msgid_result_t decoded_integers[$];

  function automatic logic [63:0] wrap_to_target(input logic [63:0] v);
    case (cfg_width)
      WIDTH_8:  return cfg_signed ? {{56{v[7]}}, v[7:0]}   : {56'd0, v[7:0]};
      WIDTH_16: return cfg_signed ? {{48{v[15]}}, v[15:0]} : {48'd0, v[15:0]};
      WIDTH_32: return cfg_signed ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
      default:  return v;
    endcase
  endfunction

  // Returns 1 when the byte completes an item (or rejects a header).
  function automatic logic decode_byte(input logic [7:0] b, output msgid_result_t r);
    logic [63:0] v;
    logic [3:0]  len;
    logic        sform;
    r     = '0;
    len   = '0;
    sform = 1'b0;
    if (payload_left != 4'd0) begin
      shift_reg    = {shift_reg[55:0], b};
      payload_left = payload_left - 4'd1;
      if (payload_left != 4'd0) return 1'b0;
      v = shift_reg;
      if (signed_form) begin
        case (item_len)
          LEN_8BIT:  v = {{56{shift_reg[7]}}, shift_reg[7:0]};
          LEN_16BIT: v = {{48{shift_reg[15]}}, shift_reg[15:0]};
          LEN_32BIT: v = {{32{shift_reg[31]}}, shift_reg[31:0]};
          default: ;
        endcase
      end
      r.value  = wrap_to_target(v);
      r.ok     = 1'b1;
      r.length = item_len;
      return 1'b1;
    end
    if (!b[7]) begin
      r.value  = wrap_to_target({56'd0, b});
      r.ok     = 1'b1;
      r.length = 4'd1;
      return 1'b1;
    end
    if (b >= NEG_FIXINT_MIN && cfg_signed) begin
      r.value  = wrap_to_target({{56{1'b1}}, b});
      r.ok     = 1'b1;
      r.length = 4'd1;
      return 1'b1;
    end
    // acceptance depends on the registers at header time
    case (b)
      HDR_UINT8:  len = LEN_8BIT;
      HDR_UINT16: if (cfg_width != WIDTH_8) len = LEN_16BIT;
      HDR_UINT32: if (cfg_width == WIDTH_32 || cfg_width == WIDTH_64) len = LEN_32BIT;
      HDR_UINT64: if (cfg_width == WIDTH_64) len = LEN_64BIT;
      HDR_INT8:   if (cfg_signed) begin
        len = LEN_8BIT;
        sform = 1'b1;
      end
      HDR_INT16:  if (cfg_signed && cfg_width != WIDTH_8) begin
        len = LEN_16BIT;
        sform = 1'b1;
      end
      HDR_INT32:  if (cfg_signed && (cfg_width == WIDTH_32 || cfg_width == WIDTH_64)) begin
        len = LEN_32BIT;
        sform = 1'b1;
      end
      HDR_INT64:  if (cfg_signed && cfg_width == WIDTH_64) begin
        len = LEN_64BIT;
        sform = 1'b1;
      end
      default: ;
    endcase
    if (len == 4'd0) return 1'b1;  // rejected: all fields zero
    payload_left = len - 4'd1;
    item_len     = len;
    signed_form  = sform;
    shift_reg    = '0;
    return 1'b0;
  endfunction

  always @(posedge clk) begin : monitor
    msgid_result_t exp_r;
    if (rst) begin
      cfg_width    = WIDTH_64;
      cfg_signed   = RESET_IS_SIGNED;
      payload_left = '0;
      shift_reg    = '0;
      signed_form  = 1'b0;
      item_len     = '0;
      mismatches   = 0;
      checked      = 0;
      decoded_integers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_integers.size() == 0) begin
          $error("unexpected result beat: value %h ok %b length %0d", value, ok, length);
          mismatches++;
        end else begin
          exp_r = decoded_integers.pop_front();
          checked++;
          if (value !== exp_r.value) begin
            $error("value: expected %h, got %h", exp_r.value, value);
            mismatches++;
          end
          if (ok !== exp_r.ok) begin
            $error("ok: expected %b, got %b", exp_r.ok, ok);
            mismatches++;
          end
          if (length !== exp_r.length) begin
            $error("length: expected %0d, got %0d", exp_r.length, length);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready && decode_byte(data_byte, exp_r))
        decoded_integers.push_back(exp_r);
      // register writes apply from the next beat on
      if (cfg_write_en) begin
        if (cfg_index == CFG_WIDTH_CODE) cfg_width = width_code_t'(cfg_data);
        else cfg_signed = cfg_data[0];
      end
    end
    pending = decoded_integers.size();
  end

endmodule

// ===== tb/tb_msgpack_integer_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_msgpack_integer_decoder_unit
// Feeds MessagePack integer encodings into the decoder: a directed set of
// edge values, rejected headers and a mid-item register change, then random
// phases under several width/signedness settings with bursty input and
// back-pressure on the result side. Checking lives in msgid_result_checker.
// ----------------------------------------------------------------------------
module tb_msgpack_integer_decoder_unit
  import msgid_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_BYTES    = 100;
  localparam int NUM_PHASES     = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic        cfg_index = CFG_WIDTH_CODE;
  logic [1:0]  cfg_data = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] value;
  logic        ok;
  logic [3:0]  length;

  int mismatches, pending, checked;

  int          bytes_sent = 0;
  int          settings_count = 0;
  int          burst_left = 0;
  int          gap_max = 0;
  int          quiet_cycles = 0;
  logic [1:0]  stall_mode = 2'd0;
  logic [7:0]  stall_tick = 8'd0;
  width_code_t cur_width = WIDTH_64;
  logic        cur_signed = RESET_IS_SIGNED;

  msgpack_integer_decoder_unit uut (
    .clk, .rst,
    .cfg_write_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .data_byte,
    .out_valid, .out_ready, .value, .ok, .length
  );

  msgid_result_checker chk (
    .clk, .rst,
    .cfg_write_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .data_byte,
    .out_valid, .out_ready, .value, .ok, .length,
    .mismatches, .pending, .checked
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: always ready, light random, periodic, or heavy random stalls
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    case (stall_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= (stall_tick[4:2] != 3'd5);
      default: out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sender works in bursts; a gap may open before any beat, mid-item included
  task automatic send_byte(input logic [7:0] b);
    logic took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    data_byte <= b;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    bytes_sent++;
  endtask

  // Header followed by nbytes of big-endian payload
  task automatic send_form(input logic [7:0] hdr, input int nbytes, input logic [63:0] payload);
    send_byte(hdr);
    for (int i = nbytes - 1; i >= 0; i--) send_byte(payload[8*i +: 8]);
  endtask

  task automatic drain_stream();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input width_code_t w, input logic s);
    drain_stream();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_WIDTH_CODE;
    cfg_data     <= w;
    @(posedge clk);
    cfg_index    <= CFG_IS_SIGNED;
    cfg_data     <= {1'b0, s};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_width  = w;
    cur_signed = s;
    settings_count++;
  endtask

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h7f;
      3:       return 8'h80;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic send_random_item();
    int          pick;
    int          k;
    logic [63:0] pay;
    logic [7:0]  hdr;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, 3);
    for (int i = 0; i < 8; i++) pay[8*i +: 8] = payload_byte();
    if (pick < 12) begin
      send_byte(8'($urandom()));
    end else if (pick < 22) begin
      send_form(8'($urandom_range(0, 127)), 0, pay);
    end else if (pick < 30) begin
      send_form(NEG_FIXINT_MIN | 8'($urandom_range(0, 31)), 0, pay);
    end else if (pick < 40) begin
      // any size, may be rejected; its payload then decodes as loose bytes
      hdr = ((pick < 35) ? HDR_UINT8 : HDR_INT8) + 8'(k);
      send_form(hdr, 1 << k, pay);
    end else begin
      k   = $urandom_range(0, int'(cur_width));
      hdr = ((cur_signed && pick[0]) ? HDR_INT8 : HDR_UINT8) + 8'(k);
      send_form(hdr, 1 << k, pay);
    end
  endtask

  initial begin
    int phase_end;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: 64-bit signed
    send_form(8'h00, 0, '0);
    send_form(8'h7f, 0, '0);
    send_form(NEG_FIXINT_MIN, 0, '0);
    send_form(8'hff, 0, '0);
    send_form(HDR_UINT8, 1, 64'hff);
    send_form(HDR_UINT16, 2, 64'hffff);
    send_form(HDR_UINT32, 4, 64'h8000_0000);
    send_form(HDR_UINT64, 8, '1);
    send_form(HDR_INT8, 1, 64'h80);
    send_form(HDR_INT16, 2, 64'h8000);
    send_form(HDR_INT32, 4, 64'h7fff_ffff);
    send_form(HDR_INT64, 8, 64'h8000_0000_0000_0000);
    send_form(8'hc1, 0, '0);

    // 8-bit unsigned: wide and signed headers refused
    reconfigure(WIDTH_8, 1'b0);
    send_form(HDR_UINT8, 1, 64'h80);
    send_form(HDR_UINT16, 0, '0);
    send_form(NEG_FIXINT_MIN, 0, '0);
    send_form(HDR_INT8, 0, '0);
    send_form(8'h7f, 0, '0);

    // 8-bit signed: uint8 above 127 wraps negative
    reconfigure(WIDTH_8, 1'b1);
    send_form(HDR_UINT8, 1, 64'hff);
    send_form(HDR_UINT32, 0, '0);

    // registers changed between header and last payload byte
    reconfigure(WIDTH_32, 1'b1);
    send_byte(HDR_INT32);
    reconfigure(WIDTH_8, 1'b0);
    send_form(8'hff, 0, '0);
    send_form(8'hff, 0, '0);
    send_form(8'hff, 0, '0);
    send_form(8'h85, 0, '0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: reconfigure(WIDTH_8, 1'b0);
        1: reconfigure(WIDTH_64, 1'b1);
        2: reconfigure(WIDTH_16, 1'b1);
        3: reconfigure(WIDTH_32, 1'b0);
        4: reconfigure(WIDTH_8, 1'b1);
        5: reconfigure(WIDTH_64, 1'b0);
        default: reconfigure(width_code_t'(2'($urandom_range(0, 3))),
                             1'($urandom_range(0, 1)));
      endcase
      stall_mode <= 2'(phase);
      gap_max = (phase % 4 == 0) ? 0 : $urandom_range(2, 8);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_random_item();
    end

    drain_stream();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d stream bytes over %0d register settings, %0d results compared.",
             bytes_sent, settings_count, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/msgid_pkg.sv
hw/rtl/msgid_step.sv
hw/rtl/msgpack_integer_decoder_unit.sv
tb/msgid_result_checker.sv
tb/tb_msgpack_integer_decoder_unit.sv
